// File: sv/dbcs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbcs_pkg
// Shared types and constants for the double-byte table codec.
// ----------------------------------------------------------------------------
package dbcs_pkg;

    localparam int CODE_BITS = 16;
    localparam int CHAR_BITS = 21;
    localparam int BYTE_BITS = 8;

    // request opcodes
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_ENCODE = 2'd1;
    localparam logic [1:0] OP_DECODE = 2'd2;

    // result kinds
    localparam logic [1:0] EMIT_NONE   = 2'd0;
    localparam logic [1:0] EMIT_ENC_HI = 2'd1;
    localparam logic [1:0] EMIT_ENC_LO = 2'd2;
    localparam logic [1:0] EMIT_DEC    = 2'd3;

    localparam logic [CHAR_BITS-1:0] GETA_CHAR        = 21'h003013;
    localparam logic [CHAR_BITS-1:0] QUESTION_CHAR    = 21'h00003F;
    localparam logic [CHAR_BITS-1:0] REPLACEMENT_CHAR = 21'h00FFFD;
    localparam logic [BYTE_BITS-1:0] ASCII_MAX        = 8'h7F;

    typedef struct packed {
        logic       capture;
        logic       clear_step;
        logic       load_write;
        logic       enc_read;
        logic       dec_read;
        logic       lead_set;
        logic [1:0] emit;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       lead_valid;
        logic       byte_high;
        logic       dbc_wide;
        logic       clr_done;
    } t_status;

endpackage
`default_nettype wire

// File: sv/dbcs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbcs_ctrl
// Sequencer: clearing sweep, request capture, table access and result steps.
// ----------------------------------------------------------------------------
module dbcs_ctrl
    import dbcs_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_ENC   = 3'd3;
    localparam logic [2:0] S_ENC2  = 3'd4;
    localparam logic [2:0] S_DEC   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_status.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                unique case (i_status.op)
                    OP_LOAD: begin
                        o_cmd.load_write = 1'b1;
                    end
                    OP_ENCODE: begin
                        o_cmd.enc_read = 1'b1;
                        n_state        = S_ENC;
                    end
                    OP_DECODE: begin
                        if (!i_status.lead_valid && i_status.byte_high) begin
                            o_cmd.lead_set = 1'b1;
                        end else begin
                            o_cmd.dec_read = 1'b1;
                            n_state        = S_DEC;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_ENC: begin
                if (i_status.dbc_wide) begin
                    o_cmd.emit = EMIT_ENC_HI;
                    n_state    = S_ENC2;
                end else begin
                    o_cmd.emit = EMIT_ENC_LO;
                    n_state    = S_IDLE;
                end
            end
            S_ENC2: begin
                o_cmd.emit = EMIT_ENC_LO;
                n_state    = S_IDLE;
            end
            S_DEC: begin
                o_cmd.emit = EMIT_DEC;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: sv/dbcs_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbcs_dp
// Datapath: both lookup tables, lead byte, fallback codes and result register.
// ----------------------------------------------------------------------------
module dbcs_dp
    import dbcs_pkg::*;
#(
    parameter int CP_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cmd                 i_cmd,
    output t_status                   o_status,
    input  wire logic [1:0]           i_op,
    input  wire logic [CHAR_BITS-1:0] i_code_point,
    input  wire logic [CODE_BITS-1:0] i_code_value,
    input  wire logic [BYTE_BITS-1:0] i_byte_in,
    output logic                      o_valid,
    output logic                      o_is_char,
    output logic [BYTE_BITS-1:0]      o_byte_out,
    output logic [CHAR_BITS-1:0]      o_char_out,
    output logic                      o_last
);

    localparam int CHAR_DEPTH = 1 << CP_BITS;
    localparam int CODE_DEPTH = 1 << CODE_BITS;
    localparam int CLR_BITS   = (CP_BITS > CODE_BITS) ? CP_BITS : CODE_BITS;

    // code -> character and character -> code tables
    logic [CHAR_BITS-1:0] r_k2c_mem [0:CODE_DEPTH-1];
    logic [CODE_BITS-1:0] r_c2k_mem [0:CHAR_DEPTH-1];

    logic [CLR_BITS-1:0]  r_clr_addr;
    logic [1:0]           r_op;
    logic [CHAR_BITS-1:0] r_cp;
    logic [CODE_BITS-1:0] r_code;
    logic [BYTE_BITS-1:0] r_byte;
    logic                 r_lead_valid;
    logic [BYTE_BITS-1:0] r_lead;
    logic [CODE_BITS-1:0] r_geta;
    logic [CODE_BITS-1:0] r_question;
    logic [CHAR_BITS-1:0] r_k2c_rd;
    logic [CODE_BITS-1:0] r_c2k_rd;
    logic                 r_enc_hit;
    logic                 r_enc_lo_pend;
    logic [BYTE_BITS-1:0] r_enc_lo;

    logic                 cp_in_range;
    logic [CODE_BITS-1:0] dec_key;
    logic [CODE_BITS-1:0] dbc;
    logic [CHAR_BITS-1:0] wc;

    assign cp_in_range = ((r_cp >> CP_BITS) == '0);
    assign dec_key     = r_lead_valid ? {r_lead, r_byte} : {{BYTE_BITS{1'b0}}, r_byte};

    // fallback chain: table, then geta mark, then question mark
    always_comb begin
        if (r_enc_hit && (r_c2k_rd != '0)) begin
            dbc = r_c2k_rd;
        end else if (r_geta != '0) begin
            dbc = r_geta;
        end else begin
            dbc = r_question;
        end
    end

    assign wc = (r_k2c_rd == '0) ? REPLACEMENT_CHAR : r_k2c_rd;

    assign o_status.op         = r_op;
    assign o_status.lead_valid = r_lead_valid;
    assign o_status.byte_high  = (r_byte > ASCII_MAX);
    assign o_status.dbc_wide   = (dbc[CODE_BITS-1:BYTE_BITS] != '0);
    assign o_status.clr_done   = (r_clr_addr == {CLR_BITS{1'b1}});

    // table ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step) begin
            r_k2c_mem[r_clr_addr[CODE_BITS-1:0]] <= '0;
            r_c2k_mem[r_clr_addr[CP_BITS-1:0]]   <= '0;
        end else if (i_cmd.load_write) begin
            r_k2c_mem[r_code] <= r_cp;
            if (cp_in_range) begin
                r_c2k_mem[r_cp[CP_BITS-1:0]] <= r_code;
            end
        end
        r_k2c_rd <= r_k2c_mem[dec_key];
        r_c2k_rd <= r_c2k_mem[r_cp[CP_BITS-1:0]];
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_op;
            r_cp   <= i_code_point;
            r_code <= i_code_value;
            r_byte <= i_byte_in;
        end
        if (i_cmd.enc_read) begin
            r_enc_hit <= cp_in_range;
        end
        if (i_cmd.emit == EMIT_ENC_HI) begin
            r_enc_lo <= dbc[BYTE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr    <= '0;
            r_lead_valid  <= 1'b0;
            r_lead        <= '0;
            r_geta        <= '0;
            r_question    <= '0;
            r_enc_lo_pend <= 1'b0;
        end else begin
            if (i_cmd.clear_step) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.load_write) begin
                if (r_cp == GETA_CHAR) begin
                    r_geta <= r_code;
                end
                if (r_cp == QUESTION_CHAR) begin
                    r_question <= r_code;
                end
            end
            if (i_cmd.lead_set) begin
                r_lead_valid <= 1'b1;
                r_lead       <= r_byte;
            end else if (i_cmd.dec_read) begin
                r_lead_valid <= 1'b0;
            end
            r_enc_lo_pend <= (i_cmd.emit == EMIT_ENC_HI);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= (i_cmd.emit != EMIT_NONE);
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.emit)
            EMIT_ENC_HI: begin
                o_is_char  <= 1'b0;
                o_byte_out <= dbc[CODE_BITS-1:BYTE_BITS];
                o_char_out <= '0;
                o_last     <= 1'b0;
            end
            EMIT_ENC_LO: begin
                o_is_char  <= 1'b0;
                // second step of a two-byte code uses the byte held back
                o_byte_out <= r_enc_lo_pend ? r_enc_lo : dbc[BYTE_BITS-1:0];
                o_char_out <= '0;
                o_last     <= 1'b1;
            end
            EMIT_DEC: begin
                o_is_char  <= 1'b1;
                o_byte_out <= '0;
                o_char_out <= wc;
                o_last     <= 1'b1;
            end
            default: begin
                o_is_char  <= o_is_char;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: sv/dbcs_table_codec_top.sv
`timescale 1ns / 1ps
`default_nettype none
// After reset the block clears both lookup tables, one entry per cycle, over
// addresses 0 to 2^max(16, CP_BITS)-1, and holds busy high meanwhile. It then
// takes a request whenever start is high and busy is low. A load writes the
// tables; a decode either only stores a lead byte or produces a character; an
// encode produces a one-byte or a two-byte code. Results pass through the
// synchronous read of the table memory and the one-result-per-cycle output
// register. Each result appears on the o_
// result ports for exactly one cycle with o_valid high; the receiver cannot
// stall it, so it must take every result as it comes. o_last marks the final
// result of a request.
// ----------------------------------------------------------------------------
// dbcs_table_codec_top
// Table-driven double-byte codepage encoder/decoder.
// ----------------------------------------------------------------------------
module dbcs_table_codec_top
    import dbcs_pkg::*;
#(
    parameter int CP_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [1:0]           i_op,
    input  wire logic [CHAR_BITS-1:0] i_code_point,
    input  wire logic [CODE_BITS-1:0] i_code_value,
    input  wire logic [BYTE_BITS-1:0] i_byte_in,
    output logic                      o_valid,
    output logic                      o_is_char,
    output logic [BYTE_BITS-1:0]      o_byte_out,
    output logic [CHAR_BITS-1:0]      o_char_out,
    output logic                      o_last
);

    t_cmd    cmd;
    t_status status;

    dbcs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    dbcs_dp #(
        .CP_BITS (CP_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_op         (i_op),
        .i_code_point (i_code_point),
        .i_code_value (i_code_value),
        .i_byte_in    (i_byte_in),
        .o_valid      (o_valid),
        .o_is_char    (o_is_char),
        .o_byte_out   (o_byte_out),
        .o_char_out   (o_char_out),
        .o_last       (o_last)
    );

endmodule
`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the double-byte table codec: a scoreboard class
// keeps its own copy of both lookup tables, the held lead byte and the two
// fallback codes, predicts the bytes or characters each request yields, and
// checks every result strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import dbcs_pkg::*;

    localparam int CP_BITS        = 16;
    localparam int CHAR_SPAN      = 1 << CP_BITS;
    localparam int WATCHDOG_LIMIT = 300000;
    localparam int NUM_ITEMS      = 600;
    localparam int POOL_SIZE      = 40;

    // opcode the block ignores
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic                 is_char;
        logic [BYTE_BITS-1:0] byte_v;
        logic [CHAR_BITS-1:0] char_v;
        logic                 last;
    } t_codec_result;

    class t_codec_scoreboard;
        logic [CHAR_BITS-1:0] char_of_code [65536];
        logic [CODE_BITS-1:0] code_of_char [65536];
        logic [8:0]           lead_byte;
        logic [CODE_BITS-1:0] geta_dbc;
        logic [CODE_BITS-1:0] question_dbc;
        t_codec_result        due_results[$];
        int                   mismatches;

        function new();
            for (int i = 0; i < 65536; i++) begin
                char_of_code[i] = '0;
                code_of_char[i] = '0;
            end
            lead_byte    = '0;
            geta_dbc     = '0;
            question_dbc = '0;
            mismatches   = 0;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function void push_char(logic [15:0] key);
            t_codec_result r;
            r.is_char = 1'b1;
            r.byte_v  = '0;
            r.char_v  = (char_of_code[key] == '0) ? REPLACEMENT_CHAR : char_of_code[key];
            r.last    = 1'b1;
            due_results.push_back(r);
        endfunction

        function void push_byte(logic [7:0] b, logic fin);
            t_codec_result r;
            r.is_char = 1'b0;
            r.byte_v  = b;
            r.char_v  = '0;
            r.last    = fin;
            due_results.push_back(r);
        endfunction

        function void take_request(logic [1:0] op, logic [CHAR_BITS-1:0] cp,
                                   logic [CODE_BITS-1:0] code, logic [BYTE_BITS-1:0] b);
            logic [CODE_BITS-1:0] dbc;
            case (op)
                OP_LOAD: begin
                    char_of_code[code] = cp;
                    if (cp < CHAR_SPAN) code_of_char[cp[15:0]] = code;
                    if (cp == GETA_CHAR) geta_dbc = code;
                    if (cp == QUESTION_CHAR) question_dbc = code;
                end
                OP_ENCODE: begin
                    dbc = '0;
                    if (cp < CHAR_SPAN) dbc = code_of_char[cp[15:0]];
                    if (dbc == '0) dbc = geta_dbc;
                    if (dbc == '0) dbc = question_dbc;
                    if (dbc > 16'h00FF) begin
                        push_byte(dbc[15:8], 1'b0);
                        push_byte(dbc[7:0], 1'b1);
                    end else begin
                        push_byte(dbc[7:0], 1'b1);
                    end
                end
                OP_DECODE: begin
                    if (lead_byte[8]) begin
                        push_char({lead_byte[7:0], b});
                        lead_byte = '0;
                    end else if (b > ASCII_MAX) begin
                        lead_byte = {1'b1, b};
                    end else begin
                        push_char({8'h00, b});
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(t_codec_result got);
            t_codec_result want;
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: is_char=%0d byte=%02h char=%06h last=%0d",
                             got.is_char, got.byte_v, got.char_v, got.last);
                return;
            end
            want = due_results.pop_front();
            if (got.is_char !== want.is_char || got.byte_v !== want.byte_v ||
                got.char_v !== want.char_v || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: expected is_char=%0d byte=%02h char=%06h last=%0d,",
                              " got is_char=%0d byte=%02h char=%06h last=%0d"},
                             want.is_char, want.byte_v, want.char_v, want.last,
                             got.is_char, got.byte_v, got.char_v, got.last);
            end
        endfunction
    endclass

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 start        = 1'b0;
    logic [1:0]           i_op         = OP_LOAD;
    logic [CHAR_BITS-1:0] i_code_point = '0;
    logic [CODE_BITS-1:0] i_code_value = '0;
    logic [BYTE_BITS-1:0] i_byte_in    = '0;
    logic                 busy;
    logic                 o_valid;
    logic                 o_is_char;
    logic [BYTE_BITS-1:0] o_byte_out;
    logic [CHAR_BITS-1:0] o_char_out;
    logic                 o_last;

    t_codec_scoreboard    sb;
    bit                   idle_on = 1'b1;
    int                   sent    = 0;
    int                   quiet_cycles = 0;
    logic [CHAR_BITS-1:0] char_pool [POOL_SIZE];
    logic [CODE_BITS-1:0] code_pool [POOL_SIZE];

    dbcs_table_codec_top #(.CP_BITS(CP_BITS)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_op        (i_op),
        .i_code_point(i_code_point),
        .i_code_value(i_code_value),
        .i_byte_in   (i_byte_in),
        .o_valid     (o_valid),
        .o_is_char   (o_is_char),
        .o_byte_out  (o_byte_out),
        .o_char_out  (o_char_out),
        .o_last      (o_last)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1)
            sb.check_result({o_is_char, o_byte_out, o_char_out, o_last});
    end

    // watchdog: any accepted request or result restarts the count
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0 && i_rst_n) || (i_rst_n && o_valid === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(input logic [1:0] op, input logic [CHAR_BITS-1:0] cp,
                                input logic [CODE_BITS-1:0] code,
                                input logic [BYTE_BITS-1:0] b);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start        <= 1'b1;
        i_op         <= op;
        i_code_point <= cp;
        i_code_value <= code;
        i_byte_in    <= b;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.take_request(op, cp, code, b);
        sent++;
    endtask

    task automatic send_byte(input logic [BYTE_BITS-1:0] b);
        send_request(OP_DECODE, 21'($urandom_range(0, 21'h10FFFF)), 16'($urandom), b);
    endtask

    task automatic send_load(input logic [CHAR_BITS-1:0] cp, input logic [CODE_BITS-1:0] code);
        send_request(OP_LOAD, cp, code, 8'($urandom));
    endtask

    task automatic send_encode(input logic [CHAR_BITS-1:0] cp);
        send_request(OP_ENCODE, cp, 16'($urandom), 8'($urandom));
    endtask

    task automatic drain;
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    initial begin
        int                   r;
        logic [CHAR_BITS-1:0] cp;
        logic [CODE_BITS-1:0] code;

        sb = new();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty tables, no fallbacks
        send_byte(8'h41);
        send_byte(8'h00);
        send_encode(21'h000041);
        send_encode(21'h1FFFFF);
        // question mark fallback, then geta over it
        send_load(QUESTION_CHAR, 16'h003F);
        send_encode(21'h001234);
        send_load(GETA_CHAR, 16'h81AC);
        send_encode(21'h001234);
        // double-byte round trip
        send_load(21'h004E00, 16'h88EA);
        send_encode(21'h004E00);
        send_byte(8'h88);
        send_byte(8'hEA);
        // wide char: code side only
        send_load(21'h01F600, 16'h9999);
        send_encode(21'h01F600);
        send_load(21'h10FFFF, 16'hFFFF);
        send_byte(8'hFF);
        send_byte(8'hFF);
        // zero on either side reads back as unmapped
        send_load(21'h000000, 16'h0041);
        send_byte(8'h41);
        send_load(21'h005555, 16'h0000);
        send_encode(21'h005555);
        // held lead survives load and encode
        send_byte(8'h88);
        send_encode(21'h004E00);
        send_load(21'h0000FF, 16'h00FF);
        send_request(OP_UNUSED, 21'h1FFFFF, 16'hFFFF, 8'hFF);
        send_byte(8'hEA);
        send_encode(21'h0000FF);
        send_byte(8'h7F);
        send_byte(8'h80);
        send_byte(8'h00);
        drain();

        for (int i = 0; i < POOL_SIZE; i++) begin
            if (i == 0) char_pool[i] = GETA_CHAR;
            else if (i == 1) char_pool[i] = QUESTION_CHAR;
            else if (i == 2) char_pool[i] = '0;
            else if (i == 3) char_pool[i] = 21'h10FFFF;
            else if (i < 8) char_pool[i] = 21'($urandom_range(21'h010000, 21'h10FFFF));
            else char_pool[i] = 21'($urandom_range(1, 16'hFFFF));
            if (i == 0) code_pool[i] = '0;
            else if (i == 1) code_pool[i] = 16'hFFFF;
            else if (i == 2) code_pool[i] = 16'h003F;
            else if (i < 10) code_pool[i] = 16'($urandom_range(1, 8'h7F));
            else if (i < 14) code_pool[i] = 16'($urandom_range(8'h80, 8'hFF));
            else code_pool[i] = {8'($urandom_range(8'h80, 8'hFF)), 8'($urandom)};
        end

        while (sent < NUM_ITEMS) begin
            if (sent > NUM_ITEMS * 85 / 100) idle_on = 1'b0;
            if (idle_on && $urandom_range(0, 149) == 0) drain();
            r = $urandom_range(0, 99);
            if (r < 18) begin
                cp   = ($urandom_range(0, 9) == 0) ? 21'($urandom_range(0, 21'h10FFFF))
                                                   : char_pool[$urandom_range(0, POOL_SIZE-1)];
                code = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                   : code_pool[$urandom_range(0, POOL_SIZE-1)];
                send_load(cp, code);
            end else if (r < 45) begin
                cp = ($urandom_range(0, 6) == 0) ? 21'($urandom_range(0, 21'h10FFFF))
                                                 : char_pool[$urandom_range(0, POOL_SIZE-1)];
                send_encode(cp);
            end else if (r < 93) begin
                if ($urandom_range(0, 4) == 0) begin
                    // noise or a broken sequence
                    send_byte(8'($urandom));
                end else begin
                    code = code_pool[$urandom_range(0, POOL_SIZE-1)];
                    if (code > 16'h00FF) begin
                        send_byte(code[15:8]);
                        send_byte(code[7:0]);
                    end else if (code <= 16'h007F) begin
                        send_byte(code[7:0]);
                    end else begin
                        send_byte(code[7:0]);
                        send_byte(8'($urandom));
                    end
                end
            end else begin
                send_request(OP_UNUSED, 21'($urandom_range(0, 21'h10FFFF)), 16'($urandom),
                             8'($urandom));
            end
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
